@@ design/mtbc_pkg.sv @@
// Package for the markup tag balance checker: transfer payload types,
// parse phase encoding, character codes and character helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtbc_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [4:0] {
    PH_OUTSIDE     = 5'b00001,
    PH_AFTER_LT    = 5'b00010,
    PH_OPEN_NAME   = 5'b00100,
    PH_CLOSE_FIRST = 5'b01000,
    PH_CLOSE_NAME  = 5'b10000
  } mtbc_phase_e;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } mtbc_in_t;

  typedef struct packed {
    logic balanced;
    logic capacity_exceeded;
  } mtbc_out_t;

  // Write strobes into the name stack
  typedef struct packed {
    logic char_en;
    logic len_en;
  } mtbc_wr_t;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_end_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_GT);
  endfunction

endpackage

`default_nettype wire

@@ design/mtbc_name_stack.sv @@
// Name stack storage: one memory of lower-cased name characters, one of
// name lengths per stack level. Synchronous reads with registered read data.
// Depends on mtbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtbc_name_stack #(
  parameter int TW = 6,
  parameter int AW = 5,
  parameter int LW = 6
) (
  input  wire logic                 clk_i,
  input  wire mtbc_pkg::mtbc_wr_t   wr_i,
  input  wire logic [TW-1:0]        wr_top_i,
  input  wire logic [AW-1:0]        wr_idx_i,
  input  wire logic [7:0]           wr_char_i,
  input  wire logic [LW-1:0]        wr_len_i,
  input  wire logic [TW-1:0]        rd_top_i,
  input  wire logic [AW-1:0]        rd_idx_i,
  output logic      [7:0]           rd_char_o,
  output logic      [LW-1:0]        rd_len_o
);
  import mtbc_pkg::*;

  localparam int CharDepth = 2 ** (TW + AW);
  localparam int LenDepth  = 2 ** TW;

  logic [7:0]    char_mem [CharDepth];
  logic [LW-1:0] len_mem  [LenDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.char_en) begin
      char_mem[{wr_top_i, wr_idx_i}] <= wr_char_i;
    end
    rd_char_o <= char_mem[{rd_top_i, rd_idx_i}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.len_en) begin
      len_mem[wr_top_i] <= wr_len_i;
    end
    rd_len_o <= len_mem[rd_top_i];
  end

endmodule

`default_nettype wire

@@ design/markup_tag_balance_checker.sv @@
// Markup tag balance checker: takes one character per cycle and gives one
// verdict (balanced, capacity exceeded) the cycle after each end-of-text
// transfer, then starts over from the reset state. The name stack memories
// are read with the address of the next parse state, so the stored
// character a closing name is compared against is ready when the next
// character arrives. A waiting verdict stalls only a further end-of-text
// transfer. No clearing pass is needed after reset.
// Depends on mtbc_pkg and mtbc_name_stack.
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_balance_checker #(
  parameter int MAX_OPEN_TAGS  = 64,
  parameter int MAX_NAME_CHARS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire mtbc_pkg::mtbc_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output mtbc_pkg::mtbc_out_t      out_data_o
);
  import mtbc_pkg::*;

  localparam int CW = $clog2(MAX_OPEN_TAGS + 1);
  localparam int TW = (MAX_OPEN_TAGS > 1) ? $clog2(MAX_OPEN_TAGS) : 1;
  localparam int LW = $clog2(MAX_NAME_CHARS + 1);
  localparam int AW = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;
  localparam logic [CW-1:0] MaxTags  = CW'(MAX_OPEN_TAGS);
  localparam logic [LW-1:0] MaxChars = LW'(MAX_NAME_CHARS);
  localparam logic [CW-1:0] CountOne = CW'(1);
  localparam logic [LW-1:0] IdxOne   = LW'(1);

  mtbc_phase_e   phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] idx_q, idx_d;
  logic          failed_q, failed_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  mtbc_out_t     out_q, out_d;

  logic          take;
  logic [7:0]    ch, ch_low;
  logic          ch_end;
  logic [CW-1:0] count_dec_q, count_dec_d;

  mtbc_wr_t      wr;
  logic [TW-1:0] wr_top;
  logic [AW-1:0] wr_idx;
  logic [LW-1:0] wr_len;
  logic [7:0]    rd_char;
  logic [LW-1:0] rd_len;

  assign in_stall_o  = in_valid_i && in_data_i.end_of_text && out_valid_q && out_stall_i;
  assign take        = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ch          = in_data_i.text_char;
  assign ch_low      = lower_of(ch);
  assign ch_end      = is_end_char(ch);
  assign count_dec_q = count_q - CountOne;
  assign count_dec_d = count_d - CountOne;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    idx_d    = idx_q;
    failed_d = failed_q;
    ovf_d    = ovf_q;
    out_d    = out_q;
    wr       = '0;
    wr_top   = count_dec_q[TW-1:0];
    wr_idx   = idx_q[AW-1:0];
    wr_len   = '0;

    if (take && in_data_i.end_of_text) begin
      out_d.balanced = !failed_q && (count_q == '0) &&
                       (phase_q != PH_CLOSE_FIRST) && (phase_q != PH_CLOSE_NAME);
      out_d.capacity_exceeded = ovf_q;
      phase_d  = PH_OUTSIDE;
      count_d  = '0;
      idx_d    = '0;
      failed_d = 1'b0;
      ovf_d    = 1'b0;
    end else if (take && !failed_q) begin
      unique case (phase_q)
        PH_OUTSIDE: begin
          if (ch == CH_LT) begin
            phase_d = PH_AFTER_LT;
          end
        end
        PH_AFTER_LT: begin
          if (ch == CH_SLASH) begin
            if (count_q == '0) begin
              failed_d = 1'b1;
            end else begin
              idx_d   = '0;
              phase_d = PH_CLOSE_FIRST;
            end
          end else if (count_q >= MaxTags) begin
            ovf_d    = 1'b1;
            failed_d = 1'b1;
          end else begin
            // push a new level; its first character comes with the '<' follower
            wr_top     = count_q[TW-1:0];
            wr_idx     = '0;
            wr.len_en  = 1'b1;
            count_d    = count_q + CountOne;
            if (ch_end) begin
              wr_len  = '0;
              phase_d = PH_OUTSIDE;
            end else begin
              wr.char_en = 1'b1;
              wr_len     = IdxOne;
              idx_d      = IdxOne;
              phase_d    = PH_OPEN_NAME;
            end
          end
        end
        PH_OPEN_NAME: begin
          if (ch_end) begin
            phase_d = PH_OUTSIDE;
          end else if (idx_q >= MaxChars) begin
            ovf_d    = 1'b1;
            failed_d = 1'b1;
          end else begin
            wr.char_en = 1'b1;
            wr.len_en  = 1'b1;
            wr_len     = idx_q + IdxOne;
            idx_d      = idx_q + IdxOne;
          end
        end
        PH_CLOSE_FIRST, PH_CLOSE_NAME: begin
          if (ch_end) begin
            if (phase_q == PH_CLOSE_NAME && idx_q == rd_len) begin
              count_d = count_dec_q;
              phase_d = PH_OUTSIDE;
            end else begin
              failed_d = 1'b1;
            end
          end else if (idx_q >= rd_len || rd_char != ch_low) begin
            failed_d = 1'b1;
          end else begin
            idx_d   = idx_q + IdxOne;
            phase_d = PH_CLOSE_NAME;
          end
        end
        default: begin
          phase_d = PH_OUTSIDE;
        end
      endcase
    end

    if (take && in_data_i.end_of_text) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OUTSIDE;
      count_q     <= '0;
      idx_q       <= '0;
      failed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      failed_q    <= failed_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Read with the next state's address so the data lines up with the next transfer
  mtbc_name_stack #(
    .TW(TW),
    .AW(AW),
    .LW(LW)
  ) u_name_stack (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .wr_top_i (wr_top),
    .wr_idx_i (wr_idx),
    .wr_char_i(ch_low),
    .wr_len_i (wr_len),
    .rd_top_i (count_dec_d[TW-1:0]),
    .rd_idx_i (idx_d[AW-1:0]),
    .rd_char_o(rd_char),
    .rd_len_o (rd_len)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxTags)
    else $error("open tag count beyond stack depth");

  a_ovf_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> failed_q)
    else $error("overflow without failure");

  a_close_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSE_FIRST || phase_q == PH_CLOSE_NAME) |-> count_q != '0)
    else $error("closing tag with empty stack");

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_data_i.end_of_text) |=>
      (out_valid_q && count_q == '0 && !failed_q && !ovf_q && phase_q == PH_OUTSIDE))
    else $error("end of text did not clear state");

endmodule

`default_nettype wire

@@ dv/markup_tag_balance_checker_tb.sv @@
// Testbench for markup_tag_balance_checker: feeds directed and random markup
// texts, predicts each verdict with its own tag-stack parser and checks every
// result transfer. Depends on mtbc_pkg and the checker RTL.
`timescale 1ns / 1ps

module markup_tag_balance_checker_tb;
  import mtbc_pkg::*;

  localparam int MAX_TAGS = 64;
  localparam int MAX_NAME = 32;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  mtbc_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mtbc_out_t out_data;

  markup_tag_balance_checker #(
    .MAX_OPEN_TAGS (MAX_TAGS),
    .MAX_NAME_CHARS(MAX_NAME)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  mtbc_in_t    char_feed_q[$];
  mtbc_out_t   verdict_q[$];
  int          failures     = 0;
  int          accepted_cnt = 0;
  logic        calm;

  // Parser state of the predictor
  logic [7:0]  stk_name[MAX_TAGS][MAX_NAME];
  int          stk_len[MAX_TAGS];
  int          stk_depth  = 0;
  mtbc_phase_e parse_st   = PH_OUTSIDE;
  int          char_idx   = 0;
  logic        fail_seen  = 1'b0;
  logic        ovf_seen   = 1'b0;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_GT);
  endfunction

  task automatic clear_parser();
    stk_depth = 0;
    parse_st  = PH_OUTSIDE;
    char_idx  = 0;
    fail_seen = 1'b0;
    ovf_seen  = 1'b0;
  endtask

  task automatic match_close_char(input logic [7:0] c);
    int top;
    top = stk_depth - 1;
    if (is_delim(c)) begin
      if (char_idx == stk_len[top]) begin
        stk_depth = top;
        parse_st  = PH_OUTSIDE;
      end else begin
        fail_seen = 1'b1;
      end
    end else if (char_idx >= stk_len[top]) begin
      fail_seen = 1'b1;
    end else if (stk_name[top][char_idx] != fold_case(c)) begin
      fail_seen = 1'b1;
    end else begin
      char_idx++;
      parse_st = PH_CLOSE_NAME;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    int top;
    case (parse_st)
      PH_OUTSIDE: begin
        if (c == CH_LT) parse_st = PH_AFTER_LT;
      end
      PH_AFTER_LT: begin
        if (c == CH_SLASH) begin
          if (stk_depth == 0) begin
            fail_seen = 1'b1;
          end else begin
            char_idx = 0;
            parse_st = PH_CLOSE_FIRST;
          end
        end else if (stk_depth >= MAX_TAGS) begin
          ovf_seen  = 1'b1;
          fail_seen = 1'b1;
        end else begin
          top = stk_depth;
          stk_len[top] = 0;
          stk_depth++;
          if (is_delim(c)) begin
            parse_st = PH_OUTSIDE;
          end else begin
            stk_name[top][0] = fold_case(c);
            stk_len[top] = 1;
            char_idx = 1;
            parse_st = PH_OPEN_NAME;
          end
        end
      end
      PH_OPEN_NAME: begin
        if (is_delim(c)) begin
          parse_st = PH_OUTSIDE;
        end else if (char_idx >= MAX_NAME) begin
          ovf_seen  = 1'b1;
          fail_seen = 1'b1;
        end else begin
          top = stk_depth - 1;
          stk_name[top][char_idx] = fold_case(c);
          char_idx++;
          stk_len[top] = char_idx;
        end
      end
      PH_CLOSE_FIRST: begin
        if (is_delim(c)) fail_seen = 1'b1;
        else match_close_char(c);
      end
      PH_CLOSE_NAME: begin
        match_close_char(c);
      end
      default: begin
        parse_st = PH_OUTSIDE;
      end
    endcase
  endtask

  // Hold idling off on both sides for a stretch in the middle of the run
  assign calm = (accepted_cnt >= 600) && (accepted_cnt < 1000);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
      if (!in_valid || !in_stall) begin
        if (char_feed_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          in_valid <= 1'b1;
          in_data  <= char_feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    mtbc_out_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        accepted_cnt <= accepted_cnt + 1;
        if (in_data.end_of_text) begin
          want.balanced = !fail_seen && stk_depth == 0 &&
                          parse_st != PH_CLOSE_FIRST && parse_st != PH_CLOSE_NAME;
          want.capacity_exceeded = ovf_seen;
          verdict_q.push_back(want);
          clear_parser();
        end else if (!fail_seen) begin
          parse_char(in_data.text_char);
        end
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with no verdict pending");
          failures++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.balanced != want.balanced) begin
            $error("balanced: expected %0b, got %0b", want.balanced, out_data.balanced);
            failures++;
          end
          if (out_data.capacity_exceeded != want.capacity_exceeded) begin
            $error("capacity_exceeded: expected %0b, got %0b",
                   want.capacity_exceeded, out_data.capacity_exceeded);
            failures++;
          end
        end
      end
    end
  end

  // Stimulus helpers
  int items_made = 0;

  task automatic push_char(input logic [7:0] c);
    char_feed_q.push_back(mtbc_in_t'{text_char: c, end_of_text: 1'b0});
    items_made++;
  endtask

  task automatic push_end();
    char_feed_q.push_back(mtbc_in_t'{text_char: 8'($urandom_range(255)), end_of_text: 1'b1});
    items_made++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_filler(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(255));
      if (c == CH_LT) c = 8'h61;
      push_char(c);
    end
  endtask

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) return c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_name_char();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 70) return 8'($urandom_range(8'h61, 8'h7A));
    if (pick < 90) return 8'($urandom_range(8'h30, 8'h39));
    do c = 8'($urandom_range(1, 255));
    while (c == CH_SPACE || c == CH_GT || c == CH_SLASH);
    return fold_case(c);
  endfunction

  function automatic string rand_name();
    string nm;
    int    len;
    int    pick;
    nm   = "";
    pick = $urandom_range(99);
    if (pick < 3) len = 0;
    else if (pick < 5) len = MAX_NAME + 1;
    else if (pick < 15) len = $urandom_range(5, MAX_NAME);
    else len = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) nm = $sformatf("%s%c", nm, rand_name_char());
    return nm;
  endfunction

  task automatic push_name(input string nm);
    for (int i = 0; i < nm.len(); i++) push_char(mixed_case(nm[i]));
  endtask

  // Mostly nested tags with random content, with a few faults injected
  task automatic nested_text();
    string open_q[$];
    string nm;
    int    steps;
    int    fault;
    steps = $urandom_range(1, 10);
    for (int s = 0; s < steps; s++) begin
      if (open_q.size() == 0 || (open_q.size() < 6 && $urandom_range(99) < 55)) begin
        nm = rand_name();
        push_char(CH_LT);
        push_name(nm);
        case ($urandom_range(3))
          0: push_str(" id=x>");
          1: push_char(CH_SPACE);
          default: push_char(CH_GT);
        endcase
        open_q.push_back(nm);
      end else begin
        nm = open_q.pop_back();
        fault = $urandom_range(39);
        if (fault == 0 && nm.len() > 1) nm = nm.substr(0, nm.len() - 2);
        else if (fault == 1) nm = $sformatf("%s%c", nm, rand_name_char());
        else if (fault == 2 && nm.len() > 0) nm[0] = (nm[0] == 8'h71) ? 8'h72 : 8'h71;
        else if (fault == 3) nm = "";
        push_str("</");
        push_name(nm);
        push_char($urandom_range(1) ? CH_GT : CH_SPACE);
      end
      push_filler($urandom_range(0, 3));
    end
    if ($urandom_range(9) != 0) begin
      while (open_q.size() != 0) begin
        push_str("</");
        push_name(open_q.pop_back());
        push_char(CH_GT);
      end
    end
    push_end();
  endtask

  task automatic noise_text();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: push_char(CH_LT);
        1: push_char(CH_SLASH);
        2: push_char(CH_GT);
        3: push_char(CH_SPACE);
        default: push_char(8'($urandom_range(255)));
      endcase
    end
    push_end();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    string long_nm;
    int    wait_cycles;

    // Directed texts
    push_end();
    push_str("<a></a>"); push_end();
    push_str("<Div class=x><P>t</p></DIV>"); push_end();
    push_str("<>"); push_end();
    push_str("< x"); push_end();
    push_str("<a></>"); push_end();
    push_str("<a></ "); push_end();
    push_str("</a>"); push_end();
    push_str("<ab></a>"); push_end();
    push_str("<a></ab>"); push_end();
    push_str("<a></b>"); push_end();
    push_str("<<a></<A>"); push_end();
    push_str("<a></a><"); push_end();
    push_str("<a></a"); push_end();
    push_str("<a></"); push_end();
    push_str("<a"); push_end();
    push_str("</x><a></a>"); push_end();
    push_char(CH_LT); push_char(8'h00); push_char(8'hFF); push_char(CH_GT);
    push_str("</"); push_char(8'h00); push_char(8'hFF); push_char(CH_GT); push_end();
    for (int i = 0; i < MAX_TAGS; i++) push_str("<t>");
    for (int i = 0; i < MAX_TAGS; i++) push_str("</T>");
    push_end();
    for (int i = 0; i <= MAX_TAGS; i++) push_str("<>");
    push_end();
    long_nm = "";
    for (int i = 0; i < MAX_NAME; i++) long_nm = $sformatf("%s%c", long_nm, 8'h61 + i % 26);
    push_char(CH_LT); push_name(long_nm); push_str("></");
    push_str(long_nm.toupper()); push_char(CH_GT); push_end();
    push_char(CH_LT); push_name(long_nm); push_str("z></a>"); push_end();

    // Hold the feed until every verdict so far has come back
    do @(negedge clk_i);
    while (char_feed_q.size() != 0 || in_valid || verdict_q.size() != 0);

    while (items_made < 1400) begin
      if ($urandom_range(3) == 0) noise_text();
      else nested_text();
    end

    while (char_feed_q.size() != 0 || in_valid) @(posedge clk_i);
    wait_cycles = 0;
    while (verdict_q.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/mtbc_pkg.sv
design/mtbc_name_stack.sv
design/markup_tag_balance_checker.sv
dv/markup_tag_balance_checker_tb.sv
